// ----- design/qau_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_pkg
// Shared types, codes and helpers of the quaternion arithmetic unit.
// ----------------------------------------------------------------------------
package qau_pkg;

    typedef enum logic [2:0] {
        OP_MUL  = 3'd0,
        OP_ADD  = 3'd1,
        OP_CONJ = 3'd2,
        OP_ROT  = 3'd3,
        OP_MAT  = 3'd4
    } t_op;

    localparam int DATA_WIDTH_DEF = 32;
    localparam int FRAC_BITS_DEF  = 16;

    // Wide intermediate values are clamped to +-2^59 and kept in 61 bits.
    localparam int WIDE_W   = 61;
    localparam int ACC_W    = 64;
    localparam int SPLIT_W  = 32;
    localparam int NUM_PROD = 16;
    localparam int NUM_SUM  = 9;

    typedef logic signed [WIDE_W-1:0] t_wide;
    typedef logic signed [ACC_W-1:0]  t_acc;
    typedef t_wide t_prods [NUM_PROD];
    typedef t_wide t_quat [4];
    typedef t_wide t_bank [NUM_SUM];

    localparam t_acc WIDE_LIM = t_acc'(64'sd1 <<< 59);

    function automatic t_wide wclamp_acc(input t_acc x);
        t_wide r;
        if (x > WIDE_LIM) begin
            r = WIDE_LIM[WIDE_W-1:0];
        end else if (x < -WIDE_LIM) begin
            r = t_wide'(-WIDE_LIM);
        end else begin
            r = x[WIDE_W-1:0];
        end
        return r;
    endfunction

    function automatic t_acc ext(input t_wide x);
        return t_acc'(x);
    endfunction

    // Hamilton product from the sixteen floored partial products, index 4*i+j
    // holding p[i]*q[j].
    function automatic t_quat hamilton(input t_prods f);
        t_quat q;
        q[0] = wclamp_acc(ext(f[0]) - ext(f[5]) - ext(f[10]) - ext(f[15]));
        q[1] = wclamp_acc(ext(f[1]) + ext(f[4]) + ext(f[11]) - ext(f[14]));
        q[2] = wclamp_acc(ext(f[2]) - ext(f[7]) + ext(f[8]) + ext(f[13]));
        q[3] = wclamp_acc(ext(f[3]) + ext(f[6]) - ext(f[9]) + ext(f[12]));
        return q;
    endfunction

endpackage

// ----- design/qau_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// qau_if
// Valid/ready channels for requests and results of the quaternion unit.
// ----------------------------------------------------------------------------
interface qau_req_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic [2:0]                   req_type;
    logic signed [DATA_WIDTH-1:0] a_w;
    logic signed [DATA_WIDTH-1:0] a_x;
    logic signed [DATA_WIDTH-1:0] a_y;
    logic signed [DATA_WIDTH-1:0] a_z;
    logic signed [DATA_WIDTH-1:0] b_w;
    logic signed [DATA_WIDTH-1:0] b_x;
    logic signed [DATA_WIDTH-1:0] b_y;
    logic signed [DATA_WIDTH-1:0] b_z;

    modport source (output valid, req_type, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                    input ready);
    modport sink   (input valid, req_type, a_w, a_x, a_y, a_z, b_w, b_x, b_y, b_z,
                    output ready);
endinterface

interface qau_res_if #(
    parameter int DATA_WIDTH = 32
);
    logic                         valid;
    logic                         ready;
    logic signed [DATA_WIDTH-1:0] val_0;
    logic signed [DATA_WIDTH-1:0] val_1;
    logic signed [DATA_WIDTH-1:0] val_2;
    logic signed [DATA_WIDTH-1:0] val_3;
    logic                         last;

    modport source (output valid, val_0, val_1, val_2, val_3, last, input ready);
    modport sink   (input valid, val_0, val_1, val_2, val_3, last, output ready);
endinterface

// ----- design/quaternion_arithmetic_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// quaternion_arithmetic_unit
// Eight register stages, r0 to r7, form the multiply, floor, sum and saturate
// pipeline. Throughput: one request per cycle when no stall holds the pipeline;
// a matrix request holds the output for its three rows, one row at a time.
// Synchronous active-low reset empties the stages.
// ----------------------------------------------------------------------------
module quaternion_arithmetic_unit
    import qau_pkg::*;
#(
    parameter int DATA_WIDTH = DATA_WIDTH_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    qau_req_if.sink          i_req,
    qau_res_if.source        o_res
);

    localparam int DW = DATA_WIDTH;
    localparam int PW = 2 * DW;
    localparam int CW = DW + WIDE_W + 2;
    localparam int LW = DW + SPLIT_W + 1;
    localparam int HW = DW + WIDE_W - SPLIT_W;
    localparam int NST = 8;

    typedef logic signed [DW-1:0] t_data;
    typedef t_data t_dvec [4];
    typedef t_data t_row [4];
    typedef t_row  t_rows [3];

    localparam logic signed [CW-1:0] LIM_C = CW'(WIDE_LIM);
    localparam t_acc ONE_C = t_acc'(64'sd1 <<< FRAC_BITS);
    localparam t_acc HI_C  = t_acc'((64'sd1 <<< (DW - 1)) - 64'sd1);
    localparam t_acc LO_C  = -HI_C - t_acc'(1);

    function automatic t_wide clamp_prod(input logic signed [CW-1:0] x);
        t_wide r;
        if (x > LIM_C) begin
            r = LIM_C[WIDE_W-1:0];
        end else if (x < -LIM_C) begin
            r = WIDE_W'(-LIM_C);
        end else begin
            r = x[WIDE_W-1:0];
        end
        return r;
    endfunction

    function automatic t_data sat_d(input t_acc x);
        t_data r;
        if (x > HI_C) begin
            r = HI_C[DW-1:0];
        end else if (x < LO_C) begin
            r = LO_C[DW-1:0];
        end else begin
            r = x[DW-1:0];
        end
        return r;
    endfunction

    logic [NST-1:0] r_v;
    logic [NST-1:0] en;

    t_op    r0_op, r1_op, r2_op, r3_op, r4_op, r5_op, r6_op;
    t_dvec  r0_a, r0_b, r1_a, r1_b, r2_a, r2_b, r3_a;
    logic signed [PW-1:0] r1_p [NUM_PROD];
    t_prods n2_f, r2_f, n5_g, r5_g;
    t_bank  n3_s, r3_s, r4_s, r5_s, n6_s, r6_s;
    logic signed [LW-1:0] n4_pl [NUM_PROD];
    logic signed [LW-1:0] r4_pl [NUM_PROD];
    logic signed [HW-1:0] n4_ph [NUM_PROD];
    logic signed [HW-1:0] r4_ph [NUM_PROD];
    logic signed [PW-1:0] n1_p [NUM_PROD];
    t_rows  n7_rows, r7_rows;
    logic [1:0] n7_nlast, r7_nlast, r7_cnt;
    logic       last_beat;
    logic       in_ok;

    // Each stage moves on when it is empty or the stage after it moves on.
    assign last_beat = (r7_cnt == r7_nlast);
    assign en[NST-1] = !r_v[NST-1] || (o_res.ready && last_beat);
    generate
        for (genvar s = 0; s < NST - 1; s++) begin : g_en
            assign en[s] = !r_v[s] || en[s+1];
        end
    endgenerate

    assign i_req.ready = en[0];
    assign in_ok = i_req.valid && (t_op'(i_req.req_type) inside {[OP_MUL:OP_MAT]});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v    <= '0;
            r7_cnt <= '0;
        end else begin
            if (en[0]) begin
                r_v[0] <= in_ok;
            end
            for (int s = 1; s < NST; s++) begin
                if (en[s]) begin
                    r_v[s] <= r_v[s-1];
                end
            end
            if (en[NST-1]) begin
                r7_cnt <= '0;
            end else if (o_res.ready) begin
                r7_cnt <= r7_cnt + 2'd1;
            end
        end
    end

    // Stage 1: sixteen exact products, operands chosen by the operation.
    always_comb begin
        t_data ma;
        t_data mb;
        for (int k = 0; k < NUM_PROD; k++) begin
            if (r0_op == OP_ROT) begin
                ma = (k / 4 == 0) ? '0 : r0_b[k/4];
            end else begin
                ma = r0_a[k/4];
            end
            mb = (r0_op == OP_MUL) ? r0_b[k%4] : r0_a[k%4];
            n1_p[k] = PW'(ma) * PW'(mb);
        end
    end

    // Stage 2: floor to the fixed-point scale and clamp. The inner product of
    // a rotation multiplies by the conjugate, so its vector terms are negated.
    always_comb begin
        logic signed [CW-1:0] x;
        for (int k = 0; k < NUM_PROD; k++) begin
            x = CW'(r1_p[k]);
            if (r1_op == OP_ROT && (k % 4) != 0) begin
                x = -x;
            end
            x = x >>> FRAC_BITS;
            n2_f[k] = clamp_prod(x);
        end
    end

    // Stage 3: sums of the products, or the simple operations.
    always_comb begin
        t_quat q;
        q = hamilton(r2_f);
        for (int m = 0; m < NUM_SUM; m++) begin
            n3_s[m] = '0;
        end
        case (r2_op)
            OP_MUL, OP_ROT: begin
                for (int m = 0; m < 4; m++) begin
                    n3_s[m] = q[m];
                end
            end
            OP_ADD: begin
                for (int m = 0; m < 4; m++) begin
                    n3_s[m] = WIDE_W'(r2_a[m]) + WIDE_W'(r2_b[m]);
                end
            end
            OP_CONJ: begin
                n3_s[0] = WIDE_W'(r2_a[0]);
                for (int m = 1; m < 4; m++) begin
                    n3_s[m] = -WIDE_W'(r2_a[m]);
                end
            end
            OP_MAT: begin
                n3_s[0] = wclamp_acc(ext(r2_f[10]) + ext(r2_f[15]));
                n3_s[1] = wclamp_acc(ext(r2_f[6]) + ext(r2_f[3]));
                n3_s[2] = wclamp_acc(ext(r2_f[7]) - ext(r2_f[2]));
                n3_s[3] = wclamp_acc(ext(r2_f[6]) - ext(r2_f[3]));
                n3_s[4] = wclamp_acc(ext(r2_f[5]) + ext(r2_f[15]));
                n3_s[5] = wclamp_acc(ext(r2_f[11]) + ext(r2_f[1]));
                n3_s[6] = wclamp_acc(ext(r2_f[7]) + ext(r2_f[2]));
                n3_s[7] = wclamp_acc(ext(r2_f[11]) - ext(r2_f[1]));
                n3_s[8] = wclamp_acc(ext(r2_f[5]) + ext(r2_f[10]));
            end
            default: begin
            end
        endcase
    end

    // Stage 4: A times the inner product, split into low and high halves.
    always_comb begin
        logic signed [HW-1:0] hb;
        for (int k = 0; k < NUM_PROD; k++) begin
            n4_pl[k] = LW'(r3_a[k/4]) * $signed({1'b0, r3_s[k%4][SPLIT_W-1:0]});
            hb = HW'($signed(r3_s[k%4][WIDE_W-1:SPLIT_W]));
            n4_ph[k] = HW'(r3_a[k/4]) * hb;
        end
    end

    // Stage 5: recombine the halves, floor and clamp.
    always_comb begin
        logic signed [CW-1:0] x;
        for (int k = 0; k < NUM_PROD; k++) begin
            x = (CW'(r4_ph[k]) <<< SPLIT_W) + CW'(r4_pl[k]);
            x = x >>> FRAC_BITS;
            n5_g[k] = clamp_prod(x);
        end
    end

    // Stage 6: outer Hamilton product of a rotation.
    always_comb begin
        t_quat q;
        q = hamilton(r5_g);
        n6_s = r5_s;
        if (r5_op == OP_ROT) begin
            n6_s[0] = q[1];
            n6_s[1] = q[2];
            n6_s[2] = q[3];
            n6_s[3] = '0;
        end
    end

    // Stage 7: scale matrix entries and saturate every field.
    always_comb begin
        t_acc two;
        two = '0;
        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 4; c++) begin
                n7_rows[r][c] = '0;
            end
        end
        if (r6_op == OP_MAT) begin
            n7_nlast = 2'd2;
            for (int r = 0; r < 3; r++) begin
                for (int c = 0; c < 3; c++) begin
                    two = ext(r6_s[3*r+c]) <<< 1;
                    n7_rows[r][c] = sat_d((r == c) ? ONE_C - two : two);
                end
            end
        end else begin
            n7_nlast = 2'd0;
            for (int c = 0; c < 4; c++) begin
                n7_rows[0][c] = sat_d(ext(r6_s[c]));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) begin
            r0_op   <= t_op'(i_req.req_type);
            r0_a[0] <= i_req.a_w;
            r0_a[1] <= i_req.a_x;
            r0_a[2] <= i_req.a_y;
            r0_a[3] <= i_req.a_z;
            r0_b[0] <= i_req.b_w;
            r0_b[1] <= i_req.b_x;
            r0_b[2] <= i_req.b_y;
            r0_b[3] <= i_req.b_z;
        end
        if (en[1]) begin
            r1_op <= r0_op;
            r1_a  <= r0_a;
            r1_b  <= r0_b;
            r1_p  <= n1_p;
        end
        if (en[2]) begin
            r2_op <= r1_op;
            r2_a  <= r1_a;
            r2_b  <= r1_b;
            r2_f  <= n2_f;
        end
        if (en[3]) begin
            r3_op <= r2_op;
            r3_a  <= r2_a;
            r3_s  <= n3_s;
        end
        if (en[4]) begin
            r4_op <= r3_op;
            r4_s  <= r3_s;
            r4_pl <= n4_pl;
            r4_ph <= n4_ph;
        end
        if (en[5]) begin
            r5_op <= r4_op;
            r5_s  <= r4_s;
            r5_g  <= n5_g;
        end
        if (en[6]) begin
            r6_op <= r5_op;
            r6_s  <= n6_s;
        end
        if (en[7]) begin
            r7_rows  <= n7_rows;
            r7_nlast <= n7_nlast;
        end
    end

    assign o_res.valid = r_v[NST-1];
    assign o_res.val_0 = r7_rows[r7_cnt][0];
    assign o_res.val_1 = r7_rows[r7_cnt][1];
    assign o_res.val_2 = r7_rows[r7_cnt][2];
    assign o_res.val_3 = r7_rows[r7_cnt][3];
    assign o_res.last  = last_beat;

`ifndef SYNTHESIS
    a_row_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v[NST-1] |-> (r7_cnt <= r7_nlast))
        else $error("result row counter passed the last row");

    a_rows_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[NST-1] && !last_beat) |=> (r_v[NST-1] && $stable(r7_nlast)))
        else $error("matrix item left the output before its last row");

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && in_ok) |=> r_v[0])
        else $error("accepted request did not enter the pipeline");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v[6] && !en[6]) |=> (r_v[6] && $stable(r6_op)))
        else $error("stalled stage lost its item");
`endif

endmodule

// ----- sim/tb_qau_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_qau_checker
// Watches the request and result channels of the quaternion unit. It works
// out the rows each accepted request should give and compares every accepted
// result with the oldest outstanding row.
// ----------------------------------------------------------------------------
module tb_qau_checker
    import qau_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    qau_req_if    req,
    qau_res_if    res,
    output int    o_fail_count,
    output int    o_pending
);

    typedef logic signed [31:0] t_val;

    typedef struct {
        t_val val_0;
        t_val val_1;
        t_val val_2;
        t_val val_3;
        logic last;
    } t_row;

    localparam longint LIM59 = longint'(1) << 59;
    localparam longint ONE   = longint'(1) << 16;

    t_row rows_due[$];
    int   fails = 0;

    assign o_fail_count = fails;
    assign o_pending    = rows_due.size();

    function automatic longint clamp59(input longint x);
        if (x > LIM59) return LIM59;
        if (x < -LIM59) return -LIM59;
        return x;
    endfunction

    // Exact product, floored by the fraction width, then clamped.
    function automatic longint fx_mul(input longint a, input longint b);
        logic signed [127:0] pa;
        logic signed [127:0] pb;
        logic signed [127:0] p;
        pa = a;
        pb = b;
        p  = (pa * pb) >>> 16;
        if (p > 128'sd1 <<< 59) return LIM59;
        if (p < -(128'sd1 <<< 59)) return -LIM59;
        return longint'(p);
    endfunction

    function automatic t_val sat32(input longint x);
        if (x > 64'sd2147483647) return 32'sh7fffffff;
        if (x < -64'sd2147483648) return 32'sh80000000;
        return t_val'(x);
    endfunction

    function automatic void ham(input longint p[4], input longint q[4], output longint r[4]);
        r[0] = clamp59(fx_mul(p[0], q[0]) - fx_mul(p[1], q[1]) - fx_mul(p[2], q[2])
                       - fx_mul(p[3], q[3]));
        r[1] = clamp59(fx_mul(p[0], q[1]) + fx_mul(p[1], q[0]) + fx_mul(p[2], q[3])
                       - fx_mul(p[3], q[2]));
        r[2] = clamp59(fx_mul(p[0], q[2]) - fx_mul(p[1], q[3]) + fx_mul(p[2], q[0])
                       + fx_mul(p[3], q[1]));
        r[3] = clamp59(fx_mul(p[0], q[3]) + fx_mul(p[1], q[2]) - fx_mul(p[2], q[1])
                       + fx_mul(p[3], q[0]));
    endfunction

    function automatic t_row mk_row(input longint v0, input longint v1, input longint v2,
                                    input longint v3, input logic lst);
        t_row r;
        r.val_0 = sat32(v0);
        r.val_1 = sat32(v1);
        r.val_2 = sat32(v2);
        r.val_3 = sat32(v3);
        r.last  = lst;
        return r;
    endfunction

    task automatic predict_quat_rows();
        longint a[4];
        longint b[4];
        longint r[4];
        longint t[4];
        longint v[4];
        longint c[4];
        longint x2, y2, z2, xy, xz, yz, wx, wy, wz;
        a = '{longint'(req.a_w), longint'(req.a_x), longint'(req.a_y), longint'(req.a_z)};
        b = '{longint'(req.b_w), longint'(req.b_x), longint'(req.b_y), longint'(req.b_z)};
        case (req.req_type)
            OP_MUL: begin
                ham(a, b, r);
                rows_due.push_back(mk_row(r[0], r[1], r[2], r[3], 1'b1));
            end
            OP_ADD: begin
                rows_due.push_back(mk_row(a[0] + b[0], a[1] + b[1], a[2] + b[2],
                                          a[3] + b[3], 1'b1));
            end
            OP_CONJ: begin
                rows_due.push_back(mk_row(a[0], -a[1], -a[2], -a[3], 1'b1));
            end
            OP_ROT: begin
                v = '{0, b[1], b[2], b[3]};
                c = '{a[0], -a[1], -a[2], -a[3]};
                ham(v, c, t);
                ham(a, t, r);
                rows_due.push_back(mk_row(r[1], r[2], r[3], 0, 1'b1));
            end
            OP_MAT: begin
                x2 = fx_mul(a[1], a[1]);
                y2 = fx_mul(a[2], a[2]);
                z2 = fx_mul(a[3], a[3]);
                xy = fx_mul(a[1], a[2]);
                xz = fx_mul(a[1], a[3]);
                yz = fx_mul(a[2], a[3]);
                wx = fx_mul(a[0], a[1]);
                wy = fx_mul(a[0], a[2]);
                wz = fx_mul(a[0], a[3]);
                rows_due.push_back(mk_row(ONE - 2 * clamp59(y2 + z2), 2 * clamp59(xy + wz),
                                          2 * clamp59(xz - wy), 0, 1'b0));
                rows_due.push_back(mk_row(2 * clamp59(xy - wz), ONE - 2 * clamp59(x2 + z2),
                                          2 * clamp59(yz + wx), 0, 1'b0));
                rows_due.push_back(mk_row(2 * clamp59(xz + wy), 2 * clamp59(yz - wx),
                                          ONE - 2 * clamp59(x2 + y2), 0, 1'b1));
            end
            default: begin
                // Undefined request codes are dropped by the block.
            end
        endcase
    endtask

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fails++;
    endtask

    always @(posedge i_clk) begin
        t_row want;
        if (i_rst_n) begin
            if (req.valid && req.ready) begin
                predict_quat_rows();
            end
            if (res.valid && res.ready) begin
                if (rows_due.size() == 0) begin
                    report_mismatch("result item with nothing outstanding");
                end else begin
                    want = rows_due.pop_front();
                    if (res.val_0 !== want.val_0)
                        report_mismatch($sformatf("val_0 %0d want %0d", res.val_0, want.val_0));
                    if (res.val_1 !== want.val_1)
                        report_mismatch($sformatf("val_1 %0d want %0d", res.val_1, want.val_1));
                    if (res.val_2 !== want.val_2)
                        report_mismatch($sformatf("val_2 %0d want %0d", res.val_2, want.val_2));
                    if (res.val_3 !== want.val_3)
                        report_mismatch($sformatf("val_3 %0d want %0d", res.val_3, want.val_3));
                    if (res.last !== want.last)
                        report_mismatch($sformatf("last %b want %b", res.last, want.last));
                end
            end
        end
    end

endmodule

// ----- sim/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Drives directed and random requests into the quaternion unit under several
// idling patterns, with one long output stall, and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top
    import qau_pkg::*;
();

    localparam int CYCLE_LIMIT = 200000;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    int   cycles = 0;
    int   fail_count;
    int   pending;
    int   tx_idle_pct = 0;
    int   rx_idle_pct = 0;
    bit   hold_req = 1'b0;
    int   hold_left = 0;

    qau_req_if #(.DATA_WIDTH(32)) req_ch ();
    qau_res_if #(.DATA_WIDTH(32)) res_ch ();

    quaternion_arithmetic_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_res   (res_ch)
    );

    tb_qau_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .req          (req_ch),
        .res          (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Receiver side: random stalls, plus one long hold-off on request.
    initial begin
        res_ch.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                hold_left = 400;
                hold_req  = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                res_ch.ready = 1'b0;
            end else begin
                res_ch.ready = ($urandom_range(0, 99) >= rx_idle_pct);
            end
        end
    end

    function automatic logic [31:0] pick_val();
        case ($urandom_range(0, 4))
            0: return $urandom;
            1: return 32'($urandom_range(0, 1 << 18)) - 32'(1 << 17);
            2: return 32'($urandom_range(0, 1 << 17)) - 32'(1 << 16);
            3: case ($urandom_range(0, 4))
                   0: return 32'h7fffffff;
                   1: return 32'h80000000;
                   2: return 32'h00010000;
                   3: return 32'hffff0000;
                   default: return 32'h0;
               endcase
            default: return 32'($urandom_range(0, 1 << 24)) - 32'(1 << 23);
        endcase
    endfunction

    task automatic send_req(input logic [2:0] op, input logic [31:0] aw, input logic [31:0] ax,
                            input logic [31:0] ay, input logic [31:0] az,
                            input logic [31:0] bw, input logic [31:0] bx,
                            input logic [31:0] by, input logic [31:0] bz);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid    = 1'b1;
        req_ch.req_type = op;
        req_ch.a_w = aw; req_ch.a_x = ax; req_ch.a_y = ay; req_ch.a_z = az;
        req_ch.b_w = bw; req_ch.b_x = bx; req_ch.b_y = by; req_ch.b_z = bz;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_random(input int count);
        logic [2:0] op;
        for (int n = 0; n < count; n++) begin
            // Mostly defined codes, with the occasional undefined one.
            op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                              : 3'($urandom_range(0, 4));
            send_req(op, pick_val(), pick_val(), pick_val(), pick_val(),
                     pick_val(), pick_val(), pick_val(), pick_val());
        end
    endtask

    localparam logic [31:0] MAXV = 32'h7fffffff;
    localparam logic [31:0] MINV = 32'h80000000;
    localparam logic [31:0] ONEV = 32'h00010000;
    localparam logic [31:0] HALF = 32'h00008000;

    initial begin
        req_ch.valid = 1'b0;
        req_ch.req_type = OP_MUL;
        req_ch.a_w = '0; req_ch.a_x = '0; req_ch.a_y = '0; req_ch.a_z = '0;
        req_ch.b_w = '0; req_ch.b_x = '0; req_ch.b_y = '0; req_ch.b_z = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part: identities, extremes, saturation and undefined codes.
        send_req(OP_MUL, ONEV, 0, 0, 0, ONEV, ONEV, ONEV, ONEV);
        send_req(OP_MUL, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV, MAXV);
        send_req(OP_MUL, MINV, MINV, MINV, MINV, MINV, MINV, MINV, MINV);
        send_req(OP_MUL, MAXV, MINV, MAXV, MINV, MINV, MAXV, MINV, MAXV);
        send_req(OP_MUL, 32'hffffffff, 1, 32'hffffffff, 1, 1, 1, 32'hffffffff, 32'hffffffff);
        send_req(OP_ADD, MAXV, MINV, 0, ONEV, MAXV, MINV, 0, 32'hffffffff);
        send_req(OP_ADD, 0, 0, 0, 0, 0, 0, 0, 0);
        send_req(OP_CONJ, MAXV, MINV, MAXV, 0, 0, 0, 0, 0);
        send_req(OP_CONJ, MINV, MAXV, MINV, 1, MAXV, MAXV, MAXV, MAXV);
        send_req(OP_ROT, ONEV, 0, 0, 0, MAXV, ONEV, MINV, HALF);
        send_req(OP_ROT, HALF, HALF, HALF, HALF, 0, ONEV, 0, 0);
        send_req(OP_ROT, HALF, HALF, HALF, HALF, 0, 0, 0, 0);
        send_req(OP_ROT, MAXV, MAXV, MINV, MINV, MAXV, MAXV, MINV, MAXV);
        send_req(OP_MAT, ONEV, 0, 0, 0, 0, 0, 0, 0);
        send_req(OP_MAT, HALF, HALF, HALF, HALF, MAXV, MAXV, MAXV, MAXV);
        send_req(OP_MAT, MAXV, MAXV, MAXV, MAXV, 0, 0, 0, 0);
        send_req(OP_MAT, MINV, MINV, MINV, MINV, 0, 0, 0, 0);
        send_req(OP_MAT, 0, 0, 0, 0, 0, 0, 0, 0);
        send_req(3'd5, ONEV, ONEV, ONEV, ONEV, ONEV, ONEV, ONEV, ONEV);
        send_req(3'd6, MAXV, 0, 0, 0, 0, 0, 0, 0);
        send_req(3'd7, MINV, 0, 0, 0, 0, 0, 0, 0);

        // Long output stall while requests keep coming, so the block backs up.
        hold_req = 1'b1;
        send_random(110);

        tx_idle_pct = 73; rx_idle_pct = 0;
        send_random(110);
        tx_idle_pct = 0;  rx_idle_pct = 73;
        send_random(110);
        tx_idle_pct = 23; rx_idle_pct = 23;
        send_random(110);
        req_ch.valid = 1'b0;

        wait (pending == 0);
        repeat (20) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
